@@ src/rtdct_pkg.sv @@
// Shared types, widths, codes and polynomial constants for the RTD code to temperature block.
package rtdct_pkg;

  localparam int CODE_W = 15;
  localparam int RES_W  = 20;
  localparam int TEMP_W = 24;
  localparam int PROD_W = CODE_W + RES_W;
  localparam int A_W    = 31;
  localparam int A2_W   = 2 * A_W;
  localparam int NB_W   = 32;
  localparam int M_W    = NB_W + RES_W;

  // Polynomial datapath widths.
  localparam int P_W   = 45;
  localparam int PM_W  = P_W + RES_W + 1;
  localparam int P5_W  = 54;

  // Pipeline shape.
  localparam int DIV_STAGES = 16;
  localparam int DIV_STEPS  = 4;
  localparam int SQ_STAGES  = 16;
  localparam int SQ_STEPS   = 2;
  localparam int QD_STAGES  = 6;
  localparam int QD_STEPS   = 4;
  localparam int POLY_LAT   = 11;
  localparam int QUAD_LAT   = DIV_STAGES + SQ_STAGES + QD_STAGES + 3;
  localparam int POLY_DLY   = QUAD_LAT - POLY_LAT;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 24'sh7FFFFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 24'sh800000;

  localparam logic signed [P_W-1:0]  POLY_C5 = 45'sd719830322984;
  localparam logic signed [P_W-1:0]  POLY_C4 = -45'sd519884588229;
  localparam logic signed [P_W-1:0]  POLY_C3 = -45'sd21734371802;
  localparam logic signed [P_W-1:0]  POLY_C2 = 45'sd2843227118;
  localparam logic signed [P_W-1:0]  POLY_C1 = 45'sd596678332;
  localparam logic signed [P5_W-1:0] POLY_C0 = -54'sd64966749061;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DISABLED = 2'd1,
    ST_FAULT    = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_ENABLE    = 3'd0,
    CFG_NOMINAL   = 3'd1,
    CFG_REFERENCE = 3'd2,
    CFG_COEF_A    = 3'd3,
    CFG_COEF_B    = 3'd4
  } cfg_idx_t;

  // Per-reading context that travels beside the arithmetic.
  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [RES_W-1:0] r;
    logic             quad;
  } ctx_t;

endpackage

@@ src/rtdct_poly.sv @@
// Pipelined Horner evaluation of the fifth-order fallback polynomial.
module rtdct_poly (
  input  logic                              clk,
  input  logic [rtdct_pkg::RES_W-1:0]       r,
  output logic signed [rtdct_pkg::TEMP_W-1:0] temp
);
  import rtdct_pkg::*;

  logic signed [PM_W-1:0] m1, m2, m3, m4, m5;
  logic signed [P_W-1:0]  p1, p2, p3, p4;
  logic signed [P5_W-1:0] p5;
  logic [RES_W-1:0]       rd [1:8];
  logic signed [PM_W-1:0] tt;

  // Round to nearest, ties towards plus infinity, then drop n bits.
  function automatic logic signed [PM_W-1:0] rnd(input logic signed [PM_W-1:0] x,
                                                 input int n);
    logic signed [PM_W-1:0] h;
    h = 1;
    h = h <<< (n - 1);
    return (x + h) >>> n;
  endfunction

  always_comb begin
    tt = rnd(PM_W'(p5), 20);
  end

  always_ff @(posedge clk) begin
    rd[1] <= r;
    for (int k = 2; k <= 8; k++) rd[k] <= rd[k-1];
    m1 <= POLY_C5 * $signed({1'b0, r});
    p1 <= POLY_C4 + P_W'(rnd(m1, 16));
    m2 <= p1 * $signed({1'b0, rd[2]});
    p2 <= POLY_C3 + P_W'(rnd(m2, 20));
    m3 <= p2 * $signed({1'b0, rd[4]});
    p3 <= POLY_C2 + P_W'(rnd(m3, 20));
    m4 <= p3 * $signed({1'b0, rd[6]});
    p4 <= POLY_C1 + P_W'(rnd(m4, 20));
    m5 <= p4 * $signed({1'b0, rd[8]});
    p5 <= POLY_C0 + P5_W'(rnd(m5, 8));
    if (tt > PM_W'(TEMP_MAX)) begin
      temp <= TEMP_MAX;
    end else if (tt < PM_W'(TEMP_MIN)) begin
      temp <= TEMP_MIN;
    end else begin
      temp <= tt[TEMP_W-1:0];
    end
  end

endmodule

@@ src/rtd_code_to_temperature_top.sv @@
// Top level: RTD converter reading to resistance and Callendar-Van Dusen temperature.
//
// One reading is taken at each rising edge where start is high and busy is low; busy is high
// only while the block comes out of reset, so a new reading may be presented every cycle and
// the block sustains one reading per clock. The result of a reading is put on the ports once it
// has passed the front registers and the divide, root and rounding-divide pipelines, marked by
// done for exactly one cycle, and is taken at the edge after that; the receiver cannot stall,
// and nothing inside ever waits. The depth is set by the longest path: the reading's ratio
// multiply, a 64-bit restoring divide by the nominal resistance (four quotient bits per
// stage), a digit-by-digit square root (two root bits per stage) and a rounding divide by
// the B coefficient, all pipelined. The fifth-order fallback polynomial is evaluated in a
// parallel pipeline and delayed to meet the quadratic path. Status 1 means the sensor is
// switched off, 2 reports a converter fault and raises clear_request, 3 means the
// resistance fell outside 1 to 2000 ohm (resistance still shows the measured value).
// Configuration is written through cfg_valid/cfg_ready, which is always ready, and should
// only be changed while no readings are in flight.
module rtd_code_to_temperature_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [15:0]                          rtd_word,
  input  logic [7:0]                           fault_byte,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [2:0]                           cfg_index,
  input  logic [31:0]                          cfg_data,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic                                 clear_request,
  output logic [rtdct_pkg::RES_W-1:0]          resistance,
  output logic signed [rtdct_pkg::TEMP_W-1:0]  temperature
);
  import rtdct_pkg::*;

  typedef struct packed {
    logic [RES_W-1:0] rem;
    logic [63:0]      num;
    logic [63:0]      quo;
  } du_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  typedef struct packed {
    logic [NB_W-1:0] rem;
    logic [23:0]     num;
    logic [23:0]     quo;
    logic            sat;
  } qd_t;

  localparam logic [PROD_W-1:0] PROD_LOW  = PROD_W'(256) << 15;
  localparam logic [PROD_W-1:0] PROD_HIGH = PROD_W'(512000) << 15;
  localparam ctx_t              CTX_IDLE  = '0;

  // Configuration registers and values derived from them.
  logic             sensor_enabled;
  logic [RES_W-1:0] nominal_resistance;
  logic [RES_W-1:0] reference_resistance;
  logic [A_W-1:0]   coef_a;
  logic [NB_W-1:0]  coef_b;
  logic [A2_W-1:0]  a2;
  logic [NB_W-1:0]  nb;

  logic accept;

  // Front stages.
  logic              a_valid, b_valid;
  logic [CODE_W-1:0] a_code;
  logic              a_fault, b_fault;
  logic [PROD_W-1:0] b_prod;

  logic [RES_W-1:0] c_r;
  logic [RES_W-1:0] c_d;
  logic [M_W-1:0]   c_m;
  logic             c_bad;
  status_t          c_status;
  logic             c_quad;

  du_t  du     [0:DIV_STAGES];
  ctx_t du_ctx [0:DIV_STAGES];
  sq_t  sq     [0:SQ_STAGES];
  ctx_t sq_ctx [0:SQ_STAGES];
  qd_t  qd     [0:QD_STAGES];
  ctx_t qd_ctx [0:QD_STAGES];

  logic             e_le;
  ctx_t             e_ctx;
  logic [A_W-1:0]   f_diff;
  logic [54:0]      f_num;
  ctx_t             g_ctx;
  logic signed [TEMP_W-1:0] g_tq;

  logic signed [TEMP_W-1:0] poly_t;
  logic signed [TEMP_W-1:0] pd [1:POLY_DLY];

  function automatic du_t du_stage(du_t s, logic [RES_W-1:0] d);
    du_t         o;
    logic [RES_W:0] t;
    o = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {o.rem, o.num[63]};
      o.num = {o.num[62:0], 1'b0};
      if (t >= {1'b0, d}) begin
        o.rem = RES_W'(t - {1'b0, d});
        o.quo = {o.quo[62:0], 1'b1};
      end else begin
        o.rem = t[RES_W-1:0];
        o.quo = {o.quo[62:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic sq_t sq_stage(sq_t s);
    sq_t         o;
    logic [35:0] sh;
    logic [35:0] tr;
    o = s;
    for (int i = 0; i < SQ_STEPS; i++) begin
      sh    = {o.rem, o.rad[63:62]};
      tr    = {2'b00, o.root, 2'b01};
      o.rad = {o.rad[61:0], 2'b00};
      if (sh >= tr) begin
        o.rem  = 34'(sh - tr);
        o.root = {o.root[30:0], 1'b1};
      end else begin
        o.rem  = sh[33:0];
        o.root = {o.root[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic qd_t qd_stage(qd_t s, logic [NB_W-1:0] d);
    qd_t           o;
    logic [NB_W:0] t;
    o = s;
    for (int i = 0; i < QD_STEPS; i++) begin
      t     = {o.rem, o.num[23]};
      o.num = {o.num[22:0], 1'b0};
      if (t >= {1'b0, d}) begin
        o.rem = NB_W'(t - {1'b0, d});
        o.quo = {o.quo[22:0], 1'b1};
      end else begin
        o.rem = t[NB_W-1:0];
        o.quo = {o.quo[22:0], 1'b0};
      end
    end
    return o;
  endfunction

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign nb        = ~coef_b + 32'd1;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_enabled       <= 1'b0;
      nominal_resistance   <= 20'd25600;
      reference_resistance <= 20'd110080;
      coef_a               <= 31'd16786021;
      coef_b               <= 32'hF64F_A809;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLE:    sensor_enabled       <= cfg_data[0];
        CFG_NOMINAL:   nominal_resistance   <= cfg_data[RES_W-1:0];
        CFG_REFERENCE: reference_resistance <= cfg_data[RES_W-1:0];
        CFG_COEF_A:    coef_a               <= cfg_data[A_W-1:0];
        CFG_COEF_B:    coef_b               <= cfg_data;
        default: ;
      endcase
    end
  end

  // A squared only changes with the configuration, so it is kept ready in a register.
  always_ff @(posedge clk) begin
    a2 <= {31'b0, coef_a} * {31'b0, coef_a};
  end

  // Resistance, range check and the scaled deviation from the nominal resistance.
  always_comb begin
    c_r   = b_prod[PROD_W-1:15];
    c_bad = (b_prod < PROD_LOW) || (b_prod > PROD_HIGH);
    c_d   = c_r - nominal_resistance;
    c_m   = {20'b0, nb} * {32'b0, c_d};
    if (!sensor_enabled) begin
      c_status = ST_DISABLED;
    end else if (b_fault) begin
      c_status = ST_FAULT;
    end else if (c_bad) begin
      c_status = ST_RANGE;
    end else begin
      c_status = ST_OK;
    end
    // The quadratic applies only for negative B, a real nominal resistance, a reading at or
    // above it, and a deviation term that cannot exceed the range of A squared.
    c_quad = coef_b[31] && (nominal_resistance != '0) && (c_r >= nominal_resistance)
             && ({12'b0, c_m[M_W-1:44]} < nominal_resistance);
  end

  always_comb begin
    e_le       = du[DIV_STAGES].quo <= {2'b00, a2};
    e_ctx      = du_ctx[DIV_STAGES];
    e_ctx.quad = du_ctx[DIV_STAGES].quad && e_le;
    f_diff     = coef_a - sq[SQ_STAGES].root[A_W-1:0];
    f_num      = {1'b0, f_diff, 23'b0} + 55'(nb[NB_W-1:1]);
  end

  always_ff @(posedge clk) begin
    a_valid <= accept && !rst;
    a_code  <= rtd_word[15:1];
    a_fault <= |fault_byte;

    b_valid <= a_valid && !rst;
    b_fault <= a_fault;
    b_prod  <= {20'b0, a_code} * {15'b0, reference_resistance};

    // Divide m * 2^18 by the nominal resistance.
    du[0]     <= '{rem: RES_W'(c_m[M_W-1:46]), num: {c_m[45:0], 18'b0}, quo: '0};
    du_ctx[0] <= '{valid: b_valid && !rst, status: c_status, r: c_r, quad: c_quad};
    for (int k = 1; k <= DIV_STAGES; k++) begin
      du[k]     <= du_stage(du[k-1], nominal_resistance);
      du_ctx[k] <= rst ? CTX_IDLE : du_ctx[k-1];
    end

    // Square root of A squared less the deviation term.
    sq[0]     <= '{rem: '0, root: '0,
                   rad: {2'b00, a2 - du[DIV_STAGES].quo[A2_W-1:0]}};
    sq_ctx[0] <= rst ? CTX_IDLE : e_ctx;
    for (int k = 1; k <= SQ_STAGES; k++) begin
      sq[k]     <= sq_stage(sq[k-1]);
      sq_ctx[k] <= rst ? CTX_IDLE : sq_ctx[k-1];
    end

    // Rounded divide of (A - root) * 2^23 by |B|, saturating at the top of the range.
    qd[0]     <= '{rem: {1'b0, f_num[54:24]}, num: f_num[23:0], quo: '0,
                   sat: (f_num[54:23] >= nb)};
    qd_ctx[0] <= rst ? CTX_IDLE : sq_ctx[SQ_STAGES];
    for (int k = 1; k <= QD_STAGES; k++) begin
      qd[k]     <= qd_stage(qd[k-1], nb);
      qd_ctx[k] <= rst ? CTX_IDLE : qd_ctx[k-1];
    end

    g_ctx <= rst ? CTX_IDLE : qd_ctx[QD_STAGES];
    g_tq  <= qd[QD_STAGES].sat ? TEMP_MAX : $signed(qd[QD_STAGES].quo);

    pd[1] <= poly_t;
    for (int k = 2; k <= POLY_DLY; k++) pd[k] <= pd[k-1];

    done          <= g_ctx.valid && !rst;
    status        <= g_ctx.status;
    clear_request <= (g_ctx.status == ST_FAULT);
    resistance    <= ((g_ctx.status == ST_OK) || (g_ctx.status == ST_RANGE)) ? g_ctx.r : '0;
    if (g_ctx.status != ST_OK) begin
      temperature <= '0;
    end else if (g_ctx.quad) begin
      temperature <= g_tq;
    end else begin
      temperature <= pd[POLY_DLY];
    end
  end

  rtdct_poly u_poly (
    .clk  (clk),
    .r    (du_ctx[0].r),
    .temp (poly_t)
  );

  // Every result must come from a reading transferred the full pipeline depth before it.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(accept, 45))
    else $error("result without a matching reading");

  // A fault clear is requested exactly when a fault is reported.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (clear_request == (status == ST_FAULT)))
    else $error("clear_request does not follow the fault status");

  // Failed readings carry no temperature, and refused ones no resistance either.
  assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (temperature == '0)
      && ((status == ST_RANGE) || (resistance == '0)))
    else $error("failed reading carries a value");

endmodule

@@ tb/rtd_code_to_temperature_top_test.sv @@
// Self-checking testbench for the RTD code to temperature block, with its own fixed-point predictor.
`timescale 1ns / 1ps

module rtd_code_to_temperature_top_test;
  import rtdct_pkg::*;

  // The run is short. This limit is many times the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = QUAD_LAT + 8;

  typedef struct {
    status_t                  status;
    logic                     clear;
    logic [RES_W-1:0]         res;
    logic signed [TEMP_W-1:0] temp;
  } reading_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [15:0] rtd_word = '0;
  logic [7:0] fault_byte = '0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic busy, cfg_ready, done, clear_request;
  logic [1:0] status;
  logic [RES_W-1:0] resistance;
  logic signed [TEMP_W-1:0] temperature;

  // The testbench's own copy of the configuration registers.
  logic               sensor_on;
  logic [RES_W-1:0]   nominal_ohms;
  logic [RES_W-1:0]   reference_ohms;
  logic [A_W-1:0]     cvd_a;
  logic signed [31:0] cvd_b;

  reading_result_t pending_results[$];
  int errors = 0;
  int readings_sent = 0;
  int results_seen = 0;
  int quad_hits = 0;
  int status_hits[4] = '{0, 0, 0, 0};
  int cycles = 0;
  bit idle_enabled = 1'b1;

  rtd_code_to_temperature_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .rtd_word(rtd_word), .fault_byte(fault_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .status(status), .clear_request(clear_request),
    .resistance(resistance), .temperature(temperature)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor. Every polynomial rescale rounds to nearest with ties upward, which on a
  // signed 64-bit value is an add of half followed by an arithmetic shift.
  // ---------------------------------------------------------------------------
  function automatic longint round_shift(longint x, int n);
    longint one;
    one = 1;
    return (x + (one << (n - 1))) >>> n;
  endfunction

  function automatic longint saturate_temp(longint t);
    if (t > 64'sd8388607) return 64'sd8388607;
    if (t < -64'sd8388608) return -64'sd8388608;
    return t;
  endfunction

  // Digit-by-digit integer square root, two bits of radicand per step.
  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Fifth-order fallback in Horner form; r is in 1/256 ohm.
  function automatic longint poly_fit(logic [63:0] r);
    longint rr, p;
    rr = longint'(r);
    p = longint'(POLY_C5);
    p = longint'(POLY_C4) + round_shift(p * rr, 16);
    p = longint'(POLY_C3) + round_shift(p * rr, 20);
    p = longint'(POLY_C2) + round_shift(p * rr, 20);
    p = longint'(POLY_C1) + round_shift(p * rr, 20);
    p = longint'(POLY_C0) + round_shift(p * rr, 8);
    return saturate_temp(round_shift(p, 20));
  endfunction

  // Quadratic Callendar-Van Dusen root. Returns 0 when the root does not apply.
  function automatic bit quad_root(input logic [63:0] r, output longint t);
    longint b;
    logic [63:0] nb, m, qh, rh, u, a2, s, num, q, r0, a;
    t = 0;
    b = longint'(cvd_b);
    r0 = 64'(nominal_ohms);
    a = 64'(cvd_a);
    if (b >= 0 || r0 == 0 || r < r0) return 1'b0;
    nb = 64'(-b);
    m = nb * (r - r0);
    qh = m / r0;
    rh = m % r0;
    if (qh >= (64'd1 << 44)) return 1'b0;
    u = (qh << 18) + (rh << 18) / r0;
    a2 = a * a;
    if (u > a2) return 1'b0;
    s = isqrt(a2 - u);
    num = (a - s) << 23;
    q = (num + nb / 2) / nb;
    t = (q > 64'd8388607) ? 64'sd8388607 : longint'(q);
    return 1'b1;
  endfunction

  function automatic reading_result_t predict_reading(logic [15:0] word, logic [7:0] fb);
    reading_result_t o;
    logic [63:0] code, prod, r;
    longint t;
    o.status = ST_OK;
    o.clear = 1'b0;
    o.res = '0;
    o.temp = '0;
    code = 64'(word >> 1);
    if (!sensor_on) begin
      o.status = ST_DISABLED;
    end else if (fb != 0) begin
      o.status = ST_FAULT;
      o.clear = 1'b1;
    end else begin
      prod = code * 64'(reference_ohms);
      r = prod >> 15;
      o.res = r[RES_W-1:0];
      if (prod < (64'd256 << 15) || prod > (64'd512000 << 15)) begin
        o.status = ST_RANGE;
      end else begin
        if (quad_root(r, t)) quad_hits++;
        else t = poly_fit(r);
        o.temp = t[TEMP_W-1:0];
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Outputs are sampled at the edge that accepts them; the
  // block updates them by nonblocking assignment, so the values read here are
  // the ones present during the strobe cycle.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("Mismatch on %s at cycle %0d: got %0d, expected %0d", field, cycles, got, want);
  endtask

  always @(posedge clk) begin
    reading_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("Unexpected result at cycle %0d with nothing outstanding.", cycles);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (clear_request !== want.clear)
          report_mismatch("clear_request", clear_request, want.clear);
        if (resistance !== want.res) report_mismatch("resistance", resistance, want.res);
        if (temperature !== want.temp) report_mismatch("temperature", temperature, want.temp);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Presents one reading and returns after the edge that takes the transfer and any idle gap.
  // Start is left high so that back-to-back readings flow every cycle; it is only
  // lowered for an idle burst or when the stream is stopped.
  task automatic send_reading(logic [15:0] word, logic [7:0] fb);
    reading_result_t want;
    start <= 1'b1;
    rtd_word <= word;
    fault_byte <= fb;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_reading(word, fb);
    status_hits[want.status]++;
    pending_results.push_back(want);
    readings_sent++;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Stops the stream and waits until every outstanding result has come back,
  // then lets the pipeline settle for its full depth.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes one register through the configuration channel; only called when idle.
  task automatic set_register(cfg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ENABLE:    sensor_on = value[0];
      CFG_NOMINAL:   nominal_ohms = value[RES_W-1:0];
      CFG_REFERENCE: reference_ohms = value[RES_W-1:0];
      CFG_COEF_A:    cvd_a = value[A_W-1:0];
      CFG_COEF_B:    cvd_b = value;
      default: ;
    endcase
  endtask

  task automatic load_config(logic en, logic [19:0] r0, logic [19:0] rref,
                             logic [30:0] a, logic [31:0] b);
    set_register(CFG_ENABLE, 32'(en));
    set_register(CFG_NOMINAL, 32'(r0));
    set_register(CFG_REFERENCE, 32'(rref));
    set_register(CFG_COEF_A, 32'(a));
    set_register(CFG_COEF_B, b);
  endtask

  function automatic logic [15:0] word_for_code(int code);
    return {code[14:0], 1'(($urandom_range(0, 1)))};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Straight out of reset the sensor is off, so every reading must report that,
  // fault or not.
  task automatic test_reset_state();
    send_reading(16'h0000, 8'h00);
    send_reading(16'hFFFF, 8'hFF);
    send_reading(16'h8000, 8'h01);
    drain_pipeline();
  endtask

  // Any nonzero fault byte wins over the measurement and requests a fault clear.
  task automatic test_fault_reporting();
    set_register(CFG_ENABLE, 32'd1);
    send_reading(16'h4000, 8'h01);
    send_reading(16'h4000, 8'h80);
    send_reading(16'hFFFF, 8'hFF);
    send_reading(16'h0001, 8'h00);
    drain_pipeline();
  endtask

  // The 1 ohm and 2000 ohm edges of the accepted window, and the bit 0 flag
  // that must be ignored.
  task automatic test_range_window();
    send_reading(16'h0000, 8'h00);
    send_reading(16'd152, 8'h00);
    send_reading(16'd155, 8'h00);
    send_reading(16'hFFFE, 8'h00);
    send_reading(16'hFFFF, 8'h00);
    drain_pipeline();
    set_register(CFG_REFERENCE, 32'hFFFFF);
    send_reading(16'd32000, 8'h00);
    send_reading(16'd32001, 8'h00);
    send_reading(16'd32002, 8'h00);
    send_reading(16'hFFFF, 8'h00);
    drain_pipeline();
  endtask

  // Register extremes push the formula choice both ways: a tiny nominal value
  // forces the root, the largest one forces the polynomial below it, and the
  // coefficient extremes drive the root into saturation or out of existence.
  task automatic test_register_extremes();
    load_config(1'b1, 20'd256, 20'hFFFFF, 31'd16786021, -32'sd162551799);
    send_reading(16'd400, 8'h00);
    send_reading(16'd20000, 8'h00);
    drain_pipeline();
    load_config(1'b1, 20'hFFFFF, 20'hFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
    send_reading(16'd16000, 8'h00);
    send_reading(16'd31999, 8'h00);
    drain_pipeline();
    load_config(1'b1, 20'd25600, 20'd110080, 31'd0, 32'h80000000);
    send_reading(16'd20000, 8'h00);
    send_reading(16'd65534, 8'h00);
    drain_pipeline();
    load_config(1'b1, 20'd25600, 20'd256, 31'h7FFFFFFF, 32'h80000000);
    send_reading(16'hFFFF, 8'h00);
    drain_pipeline();
    set_register(CFG_ENABLE, 32'd0);
    send_reading(16'h2345, 8'h00);
    drain_pipeline();
  endtask

  // A random but legal register set: half near a platinum sensor, half anywhere.
  task automatic randomise_config();
    logic [19:0] r0, rref;
    logic [30:0] a;
    logic [31:0] b;
    r0 = ($urandom_range(0, 1) == 1) ? 20'($urandom_range(25000, 26200))
                                     : 20'($urandom_range(256, 1048575));
    rref = ($urandom_range(0, 1) == 1) ? 20'($urandom_range(100000, 120000))
                                       : 20'($urandom_range(256, 1048575));
    a = ($urandom_range(0, 1) == 1) ? 31'd16786021 : 31'($urandom_range(0, 32'h7FFFFFFF));
    case ($urandom_range(0, 3))
      0: b = 32'hFFFFFFFF;
      1: b = 32'h80000000;
      2: b = -32'sd162551799;
      default: b = -32'($urandom_range(1, 32'h7FFFFFFF));
    endcase
    load_config(($urandom_range(0, 7) != 0), r0, rref, a, b);
  endtask

  // Mostly clean readings with random codes, some faults, and a share of codes
  // near the window edges.
  task automatic random_readings(int n);
    int code;
    logic [7:0] fb;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: code = $urandom_range(0, 200);
        1: code = $urandom_range(15900, 16100);
        default: code = $urandom_range(0, 32767);
      endcase
      fb = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      send_reading(word_for_code(code), fb);
    end
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 8; phase++) begin
      randomise_config();
      random_readings(100);
      drain_pipeline();
    end
  endtask

  // The closing stretch runs at full rate with no gaps at all.
  task automatic test_full_rate_tail();
    idle_enabled = 1'b0;
    load_config(1'b1, 20'd25600, 20'd110080, 31'd16786021, -32'sd162551799);
    random_readings(60);
    drain_pipeline();
  endtask

  initial begin
    sensor_on = 1'b0;
    nominal_ohms = 20'd25600;
    reference_ohms = 20'd110080;
    cvd_a = 31'd16786021;
    cvd_b = -32'sd162551799;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_fault_reporting();
    test_range_window();
    test_register_extremes();
    test_random_configs();
    test_full_rate_tail();
    $display("Sent %0d readings and checked %0d results over fixed and random register sets.",
             readings_sent, results_seen);
    $display("Outcomes: ok %0d (quadratic root %0d), disabled %0d, fault %0d, out of range %0d.",
             status_hits[0], quad_hits, status_hits[1], status_hits[2], status_hits[3]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
